// File: hw/rtl/spq_pkg.sv
// Shared types and constants of the slot priority queue.
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

	localparam int SLOTS         = 16;
	localparam int PAYLOAD_WIDTH = 32;
	localparam int PRIO_W        = 7;
	localparam int IDX_W         = $clog2(SLOTS);
	localparam int CNT_W         = $clog2(SLOTS + 1);
	localparam int FIFO_DEPTH    = 2;

	localparam logic [PRIO_W-1:0] PRIO_MAX      = {PRIO_W{1'b1}};
	localparam logic [PRIO_W-1:0] CEILING_RESET = PRIO_W'(100);

	typedef enum logic [1:0] {
		KIND_ENQ       = 2'd0,
		KIND_ENQ_FRONT = 2'd1,
		KIND_DEQ       = 2'd2,
		KIND_FLUSH     = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_DONE = 2'd0,
		STATUS_NONE = 2'd1,
		STATUS_FULL = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RAISE,
		S_INSERT,
		S_FLUSH,
		S_SEEK,
		S_TAKE,
		S_GRAB,
		S_SCAN,
		S_FETCH,
		S_REPORT
	} state_t;

	typedef struct packed {
		kind_t                    kind;
		logic [PAYLOAD_WIDTH-1:0] payload;
	} in_item_t;

	typedef struct packed {
		status_t                  status;
		logic [PAYLOAD_WIDTH-1:0] taken_payload;
		logic                     head_present;
		logic [PAYLOAD_WIDTH-1:0] head_payload;
		logic [CNT_W-1:0]         occupancy;
	} out_item_t;

	// Classified command handed from the front to the back
	typedef struct packed {
		logic                     raise;
		logic                     insert;
		logic                     take;
		logic                     flush;
		logic [PAYLOAD_WIDTH-1:0] payload;
	} cmd_t;

endpackage
`default_nettype wire

// File: hw/rtl/slot_priority_queue.sv
// Top level of the slot priority queue: front, back, ceiling register and result register.
// The back carries out one command at a time and steps through the slot table one slot
//   per cycle, once for a dequeue's search and once for the head and occupancy report;
//   it takes no new command until its result is taken. A two-entry input queue and the
//   result register let pushes and pops proceed while the back works.
// Reset (arst_n low, asynchronous): all slots invalid, ceiling 100, queues empty.
`timescale 1ns / 1ps
`default_nettype none
module slot_priority_queue (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	output logic                            full,
	input  wire spq_pkg::in_item_t          item,
	output logic                            empty,
	input  wire logic                       pop,
	output spq_pkg::out_item_t              result,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [spq_pkg::PRIO_W-1:0] cfg_data
);
	import spq_pkg::*;

	logic              cmd_valid;
	logic              cmd_ready;
	cmd_t              cmd;
	logic              res_valid;
	logic              res_ready;
	out_item_t         res;
	logic [PRIO_W-1:0] ceiling_q;
	out_item_t         result_q;
	logic              result_full_q;

	// Front: accept and classify items, hold them until the back is free
	spq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// Back: execute one command at a time against the slot table
	spq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.ceiling   (ceiling_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Ceiling register; a write transfer is taken in any cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_q <= CEILING_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ceiling_q <= cfg_data;
		end
	end

	// Result register: load when empty or being drained in the same cycle
	assign res_ready = !result_full_q || pop;
	assign empty     = !result_full_q;
	assign result    = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_full_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			result_full_q <= 1'b1;
		end else if (pop) begin
			result_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			result_q <= res;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/spq_front.sv
// Front end: accept input items, classify them and hold them in a short queue.
`timescale 1ns / 1ps
`default_nettype none
module spq_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire spq_pkg::in_item_t item,
	output logic                  cmd_valid,
	input  wire logic             cmd_ready,
	output spq_pkg::cmd_t         cmd
);
	import spq_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);

	cmd_t                           entry_q [FIFO_DEPTH];
	logic [PTR_W-1:0]               wr_ptr_q;
	logic [PTR_W-1:0]               rd_ptr_q;
	logic [$clog2(FIFO_DEPTH+1)-1:0] count_q;
	cmd_t                           classified;
	logic                           do_push;
	logic                           do_pop;

	always_comb begin
		classified         = '0;
		classified.payload = item.payload;
		unique case (item.kind)
			KIND_ENQ: begin
				classified.insert = 1'b1;
			end
			KIND_ENQ_FRONT: begin
				classified.raise  = 1'b1;
				classified.insert = 1'b1;
			end
			KIND_DEQ: begin
				classified.take = 1'b1;
			end
			KIND_FLUSH: begin
				classified.flush = 1'b1;
			end
			default: begin
				classified.flush = 1'b1;
			end
		endcase
	end

	assign full      = (count_q == ($clog2(FIFO_DEPTH+1))'(FIFO_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= classified;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/spq_back.sv
// Back end: slot table, payload memory and the sequencer that carries out commands.
`timescale 1ns / 1ps
`default_nettype none
module spq_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cmd_valid,
	output logic                               cmd_ready,
	input  wire spq_pkg::cmd_t                 cmd,
	input  wire logic [spq_pkg::PRIO_W-1:0]    ceiling,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output spq_pkg::out_item_t                 res
);
	import spq_pkg::*;

	state_t                   state_q;
	state_t                   state_d;
	cmd_t                     cmd_q;
	logic [SLOTS-1:0]         valid_q;
	logic [PRIO_W-1:0]        prio_q [SLOTS];
	logic [IDX_W-1:0]         idx_q;
	logic [IDX_W-1:0]         best_idx_q;
	logic [PRIO_W-1:0]        best_prio_q;
	logic                     found_q;
	logic [CNT_W-1:0]         count_q;
	status_t                  status_q;
	logic [PAYLOAD_WIDTH-1:0] taken_q;
	logic [PAYLOAD_WIDTH-1:0] pay_mem [SLOTS];
	logic [PAYLOAD_WIDTH-1:0] rdata_q;

	logic                     scan_last;
	logic [IDX_W:0]           free_slot;
	logic                     accept;
	logic                     scan_init;
	logic                     scan_step;
	logic                     raise_en;
	logic                     insert_en;
	logic                     flush_en;
	logic                     take_en;
	logic                     grab_en;
	logic                     rd_en;

	// Lowest-index free slot: {found, index}
	function automatic logic [IDX_W:0] find_free(input logic [SLOTS-1:0] v);
		logic [IDX_W:0] r;
		r = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!v[i]) begin
				r = {1'b1, IDX_W'(i)};
			end
		end
		return r;
	endfunction

	assign scan_last = (idx_q == IDX_W'(SLOTS - 1));
	assign free_slot = find_free(valid_q);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					if (cmd.raise) begin
						state_d = S_RAISE;
					end else if (cmd.insert) begin
						state_d = S_INSERT;
					end else if (cmd.take) begin
						state_d = S_SEEK;
					end else begin
						state_d = S_FLUSH;
					end
				end
			end
			S_RAISE:  state_d = S_INSERT;
			S_INSERT: state_d = S_SCAN;
			S_FLUSH:  state_d = S_SCAN;
			S_SEEK: begin
				if (scan_last) begin
					state_d = S_TAKE;
				end
			end
			S_TAKE:   state_d = S_GRAB;
			S_GRAB:   state_d = S_SCAN;
			S_SCAN: begin
				if (scan_last) begin
					state_d = S_FETCH;
				end
			end
			S_FETCH:  state_d = S_REPORT;
			S_REPORT: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default:  state_d = S_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		cmd_ready = 1'b0;
		scan_init = 1'b0;
		scan_step = 1'b0;
		raise_en  = 1'b0;
		insert_en = 1'b0;
		flush_en  = 1'b0;
		take_en   = 1'b0;
		grab_en   = 1'b0;
		rd_en     = 1'b0;
		res_valid = 1'b0;
		unique case (state_q) inside
			S_IDLE: begin
				cmd_ready = 1'b1;
				scan_init = cmd_valid && !cmd.raise && !cmd.insert && cmd.take;
			end
			S_RAISE: begin
				raise_en = 1'b1;
			end
			S_INSERT: begin
				insert_en = 1'b1;
				scan_init = 1'b1;
			end
			S_FLUSH: begin
				flush_en  = 1'b1;
				scan_init = 1'b1;
			end
			S_SEEK, S_SCAN: begin
				scan_step = 1'b1;
			end
			S_TAKE: begin
				take_en = 1'b1;
				rd_en   = found_q;
			end
			S_GRAB: begin
				grab_en   = 1'b1;
				scan_init = 1'b1;
			end
			S_FETCH: begin
				rd_en = found_q;
			end
			S_REPORT: begin
				res_valid = 1'b1;
			end
			default: begin
				cmd_ready = 1'b0;
			end
		endcase
	end

	assign accept = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				prio_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (raise_en) begin
				for (int i = 0; i < SLOTS; i++) begin
					if (valid_q[i] && prio_q[i] != PRIO_MAX) begin
						prio_q[i] <= prio_q[i] + 1'b1;
					end
				end
			end
			if (insert_en && free_slot[IDX_W]) begin
				valid_q[free_slot[IDX_W-1:0]] <= 1'b1;
				prio_q[free_slot[IDX_W-1:0]]  <= '0;
			end
			if (flush_en) begin
				valid_q <= '0;
			end
			if (take_en && found_q) begin
				valid_q[best_idx_q] <= 1'b0;
			end
		end
	end

	// Scan, status and result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd;
			status_q <= STATUS_DONE;
			taken_q  <= '0;
		end
		if (insert_en && !free_slot[IDX_W]) begin
			status_q <= STATUS_FULL;
		end
		if (take_en && !found_q) begin
			status_q <= STATUS_NONE;
		end
		if (grab_en && found_q) begin
			taken_q <= rdata_q;
		end
		if (scan_init) begin
			idx_q       <= '0;
			best_idx_q  <= '0;
			best_prio_q <= ceiling;
			found_q     <= 1'b0;
			count_q     <= '0;
		end else if (scan_step) begin
			idx_q   <= idx_q + 1'b1;
			count_q <= count_q + CNT_W'(valid_q[idx_q]);
			if (valid_q[idx_q] && prio_q[idx_q] < best_prio_q) begin
				best_prio_q <= prio_q[idx_q];
				best_idx_q  <= idx_q;
				found_q     <= 1'b1;
			end
		end
	end

	// Payload memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (insert_en && free_slot[IDX_W]) begin
			pay_mem[free_slot[IDX_W-1:0]] <= cmd_q.payload;
		end
		if (rd_en) begin
			rdata_q <= pay_mem[best_idx_q];
		end
	end

	always_comb begin
		res.status        = status_q;
		res.taken_payload = taken_q;
		res.head_present  = found_q;
		res.head_payload  = found_q ? rdata_q : '0;
		res.occupancy     = count_q;
	end

endmodule
`default_nettype wire
